// ===== rtl/button_long_press_autorepeat_defines.svh =====
// Assertion helpers for the button long-press block.
`ifndef BUTTON_LONG_PRESS_AUTOREPEAT_DEFINES_SVH
`define BUTTON_LONG_PRESS_AUTOREPEAT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock, off during reset.
`define BLP_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("blp check failed");
// Next-cycle implication, sampled on the rising clock, off during reset.
`define BLP_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("blp check failed");
`else
`define BLP_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define BLP_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

// ===== rtl/blp_pkg.sv =====
package blp_pkg;

  // Button states as reported on the result word.
  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_LONG     = 2'd2,
    ST_LONGER   = 2'd3
  } btn_state_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SCAN_PERIOD     = 3'd0,
    REG_LONG_THRESHOLD  = 3'd1,
    REG_LONGER_THRESHOLD = 3'd2,
    REG_LONG_REPEAT     = 3'd3,
    REG_LONGER_REPEAT   = 3'd4,
    REG_REPEAT_ENABLE   = 3'd5,
    REG_LONGER_ENABLE   = 3'd6
  } cfg_idx_t;

  localparam int unsigned CntW = 8;
  localparam logic [CntW-1:0] HoldMax = 8'hff;

  localparam logic [CntW-1:0] ScanPeriodRst   = 8'd25;
  localparam logic [CntW-1:0] LongThrRst      = 8'd80;
  localparam logic [CntW-1:0] LongerThrRst    = 8'd200;
  localparam logic [CntW-1:0] LongRepeatRst   = 8'd10;
  localparam logic [CntW-1:0] LongerRepeatRst = 8'd4;
  localparam logic            RepeatEnRst     = 1'b1;
  localparam logic            LongerEnRst     = 1'b1;

  // Live configuration handed to the engine.
  typedef struct packed {
    logic [CntW-1:0] scan_period;
    logic [CntW-1:0] long_thr;
    logic [CntW-1:0] longer_thr;
    logic [CntW-1:0] long_rpt;
    logic [CntW-1:0] longer_rpt;
    logic            repeat_en;
    logic            longer_en;
  } cfg_t;

  // Event produced by one tick.
  typedef struct packed {
    logic       fire;
    btn_state_t state;
    logic       rpt;
  } evt_t;

endpackage

// ===== rtl/blp_cfg_regs.sv =====
module blp_cfg_regs
  import blp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [7:0]  wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_q;

  // Decode and store register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.scan_period <= ScanPeriodRst;
      cfg_q.long_thr    <= LongThrRst;
      cfg_q.longer_thr  <= LongerThrRst;
      cfg_q.long_rpt    <= LongRepeatRst;
      cfg_q.longer_rpt  <= LongerRepeatRst;
      cfg_q.repeat_en   <= RepeatEnRst;
      cfg_q.longer_en   <= LongerEnRst;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        REG_SCAN_PERIOD:      cfg_q.scan_period <= wr_data;
        REG_LONG_THRESHOLD:   cfg_q.long_thr    <= wr_data;
        REG_LONGER_THRESHOLD: cfg_q.longer_thr  <= wr_data;
        REG_LONG_REPEAT:      cfg_q.long_rpt    <= wr_data;
        REG_LONGER_REPEAT:    cfg_q.longer_rpt  <= wr_data;
        REG_REPEAT_ENABLE:    cfg_q.repeat_en   <= wr_data[0];
        REG_LONGER_ENABLE:    cfg_q.longer_en   <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule

// ===== rtl/blp_engine.sv =====
module blp_engine
  import blp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  step,
  input  logic  level,
  output evt_t  evt
);

  logic [CntW-1:0] tick_countdown;
  logic            last_pressed;
  btn_state_t      current_state;
  logic [CntW-1:0] hold_count;
  logic [CntW-1:0] repeat_count;

  logic [CntW-1:0] countdown_next;
  logic            sample;
  logic            pressed;
  logic            level_change;
  logic [CntW-1:0] hold_next;
  logic [CntW-1:0] repeat_next;
  logic            repeated;
  btn_state_t      state_next;

  assign pressed        = ~level;
  assign countdown_next = tick_countdown - 8'd1;
  assign sample         = (countdown_next == '0);
  assign level_change   = (pressed != last_pressed);

  // Next state: level change, hold counter, repeat counter, thresholds.
  always_comb begin
    hold_next   = hold_count;
    repeat_next = repeat_count;
    repeated    = 1'b0;
    state_next  = current_state;
    if (level_change) begin
      hold_next   = '0;
      repeat_next = '0;
      state_next  = pressed ? ST_PRESSED : ST_RELEASED;
    end else if (current_state != ST_RELEASED) begin
      if (hold_count != HoldMax) begin
        hold_next = hold_count + 8'd1;
      end
      if (cfg.repeat_en) begin
        if (repeat_count != '0) begin
          repeat_next = repeat_count - 8'd1;
          repeated    = (repeat_next == '0);
        end else if (current_state == ST_LONG) begin
          repeat_next = cfg.long_rpt - 8'd1;
        end else if (current_state == ST_LONGER && cfg.longer_en) begin
          repeat_next = cfg.longer_rpt - 8'd1;
        end
      end
      // Long threshold wins; a match cancels a repeat on the same scan.
      if (hold_next == cfg.long_thr) begin
        state_next = ST_LONG;
        repeated   = 1'b0;
      end else if (cfg.longer_en && hold_next == cfg.longer_thr) begin
        state_next = ST_LONGER;
        repeated   = 1'b0;
      end
    end
  end

  // Event output: on a sample that changes state or raises a repeat.
  always_comb begin
    evt.fire  = sample && ((state_next != current_state) || repeated);
    evt.state = state_next;
    evt.rpt   = repeated;
  end

  // Advance the countdown every tick, the rest on samples only.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_countdown <= ScanPeriodRst;
      last_pressed   <= 1'b0;
      current_state  <= ST_RELEASED;
      hold_count     <= '0;
      repeat_count   <= '0;
    end else if (step) begin
      if (sample) begin
        tick_countdown <= cfg.scan_period;
        last_pressed   <= pressed;
        current_state  <= state_next;
        hold_count     <= hold_next;
        repeat_count   <= repeat_next;
      end else begin
        tick_countdown <= countdown_next;
      end
    end
  end

endmodule

// ===== rtl/button_long_press_autorepeat.sv =====
// Button long-press detector with auto-repeat. Each input word is one
// millisecond tick carrying the raw active-low pin level; the button is
// sampled once every scan_period ticks, and a result word (new state, or a
// repeat flag in the long and longer states) comes out only on a state change
// or repeat. Ticks are taken at one per clock: a tick is captured in an input
// register, evaluated in a single pass of counter and compare logic and, when
// it raises an event, written into the output register. The input side only
// stalls when a tick that raises an event meets a full output register that
// is not being read. Configuration writes are taken in every cycle and should
// be made while no tick is pending.
`include "button_long_press_autorepeat_defines.svh"

module button_long_press_autorepeat
  import blp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       button_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] button_state,
  output logic       is_repeat,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t cfg;
  evt_t evt;

  logic s1_valid;
  logic s1_level;
  logic s1_adv;
  logic out_load;

  assign cfg_ready = 1'b1;

  blp_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  blp_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .step  (s1_adv),
    .level (s1_level),
    .evt   (evt)
  );

  // Hold a tick only while its event cannot reach the output register.
  assign s1_adv   = s1_valid && (!evt.fire || !out_valid || out_ready);
  assign out_load = s1_adv && evt.fire;
  assign in_ready = !s1_valid || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_level <= button_level;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      button_state <= evt.state;
      is_repeat    <= evt.rpt;
    end
  end

  // A repeat word only comes from the long or longer state.
  `BLP_ASSERT_IMP(a_rpt_state, clk, rst, out_valid && is_repeat,
    button_state == ST_LONG || button_state == ST_LONGER)
  // A held tick means a full output register that is not being read.
  `BLP_ASSERT_IMP(a_stall_cause, clk, rst, s1_valid && !s1_adv,
    out_valid && !out_ready)
  // A loaded event is on the output in the next cycle.
  `BLP_ASSERT_NXT(a_out_load, clk, rst, out_load, out_valid)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import blp_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int HoldOffCycles = 200;
  localparam int SettleCycles  = 8;
  localparam int NumSettings   = 9;
  localparam int NumRows       = 15;

  // How a tick's expected result is obtained
  typedef enum logic [1:0] {
    CHK_NONE,
    CHK_GIVEN,
    CHK_MODEL
  } chk_t;

  typedef struct packed {
    btn_state_t state;
    logic       rpt;
  } press_evt_t;

  typedef struct packed {
    logic       setup;
    logic       level;
    logic [9:0] reps;
    chk_t       chk;
    btn_state_t state;
    logic       rpt;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] scan;
    logic [7:0] long_thr;
    logic [7:0] longer_thr;
    logic [7:0] long_rpt;
    logic [7:0] longer_rpt;
    logic [7:0] repeat_en;
    logic [7:0] longer_en;
    logic [6:0] tx_idle;
    logic [6:0] rx_idle;
    logic [9:0] items;
    logic [9:0] hold_first;
    logic [9:0] hold_rand;
    logic       squeeze;
  } setting_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       button_level = 1'b1;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] button_state;
  logic       is_repeat;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // Expectation attached to the word on the input channel
  chk_t       tick_chk = CHK_NONE;
  btn_state_t tick_state = ST_RELEASED;
  logic       tick_rpt = 1'b0;

  int   tx_idle = 0;
  int   rx_idle = 0;
  logic rx_hold = 1'b0;
  logic squeeze_req = 1'b0;

  // Predictor state and register copy
  cfg_t       cfg_mirror;
  logic [7:0] bs_countdown;
  logic       bs_last_pressed;
  btn_state_t bs_state;
  logic [7:0] bs_hold;
  logic [7:0] bs_repeat;

  press_evt_t button_events[$];

  int errors = 0;
  int ticks_taken = 0;
  int events_seen = 0;
  int repeats_seen = 0;
  int stall_cycles = 0;
  int quiet_cycles = 0;

  // Directed ticks: reset timing first, then one full press through long and longer
  stim_row_t dir_rows [0:NumRows-1] = '{
    '{1'b0, 1'b1, 10'd24, CHK_NONE,  ST_RELEASED, 1'b0},
    '{1'b0, 1'b0, 10'd1,  CHK_GIVEN, ST_PRESSED,  1'b0},
    '{1'b0, 1'b1, 10'd25, CHK_GIVEN, ST_RELEASED, 1'b0},
    '{1'b1, 1'b1, 10'd25, CHK_NONE,  ST_RELEASED, 1'b0},
    '{1'b0, 1'b0, 10'd1,  CHK_GIVEN, ST_PRESSED,  1'b0},
    '{1'b0, 1'b0, 10'd2,  CHK_NONE,  ST_RELEASED, 1'b0},
    '{1'b0, 1'b0, 10'd1,  CHK_GIVEN, ST_LONG,     1'b0},
    '{1'b0, 1'b0, 10'd1,  CHK_NONE,  ST_RELEASED, 1'b0},
    '{1'b0, 1'b0, 10'd1,  CHK_GIVEN, ST_LONGER,   1'b0},
    '{1'b0, 1'b0, 10'd1,  CHK_NONE,  ST_RELEASED, 1'b0},
    '{1'b0, 1'b0, 10'd1,  CHK_GIVEN, ST_LONGER,   1'b1},
    '{1'b0, 1'b0, 10'd1,  CHK_NONE,  ST_RELEASED, 1'b0},
    '{1'b0, 1'b0, 10'd1,  CHK_GIVEN, ST_LONGER,   1'b1},
    '{1'b0, 1'b1, 10'd1,  CHK_GIVEN, ST_RELEASED, 1'b0},
    '{1'b0, 1'b1, 10'd2,  CHK_NONE,  ST_RELEASED, 1'b0}
  };

  // Register settings; entry 0 serves the directed ticks
  setting_t settings [0:NumSettings-1] = '{
    '{8'd1, 8'd3,   8'd5,   8'd2,   8'd2,   8'h01, 8'h01, 7'd6,  7'd49,
      10'd0,   10'd0,   10'd1,  1'b0},
    '{8'd1, 8'd3,   8'd6,   8'd2,   8'd1,   8'h01, 8'h01, 7'd6,  7'd49,
      10'd40,  10'd12,  10'd14, 1'b0},
    '{8'd2, 8'd1,   8'd1,   8'd1,   8'd3,   8'h01, 8'h01, 7'd6,  7'd49,
      10'd30,  10'd20,  10'd24, 1'b0},
    '{8'd1, 8'd5,   8'd2,   8'd3,   8'd2,   8'h01, 8'h01, 7'd49, 7'd6,
      10'd30,  10'd12,  10'd14, 1'b0},
    '{8'd1, 8'd2,   8'd0,   8'd0,   8'd255, 8'h01, 8'h01, 7'd49, 7'd6,
      10'd30,  10'd20,  10'd8,  1'b0},
    '{8'd1, 8'd255, 8'd255, 8'd2,   8'd2,   8'h01, 8'h01, 7'd0,  7'd0,
      10'd259, 10'd258, 10'd6,  1'b0},
    '{8'd3, 8'd4,   8'd8,   8'd3,   8'd2,   8'hfe, 8'h01, 7'd0,  7'd0,
      10'd40,  10'd40,  10'd40, 1'b0},
    '{8'd1, 8'd3,   8'd5,   8'd2,   8'd2,   8'h01, 8'h00, 7'd0,  7'd0,
      10'd40,  10'd15,  10'd15, 1'b1},
    '{8'd0, 8'd1,   8'd2,   8'd255, 8'd255, 8'h01, 8'h01, 7'd0,  7'd0,
      10'd257, 10'd256, 10'd8,  1'b0}
  };

  button_long_press_autorepeat DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .button_level (button_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_state (button_state),
    .is_repeat    (is_repeat),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the button tracker by one tick; fire marks a result word
  function automatic void track_button(input logic lvl, output logic fire,
                                       output press_evt_t ev);
    logic       pressed;
    logic       rpt;
    btn_state_t nxt;
    pressed = ~lvl;
    rpt = 1'b0;
    nxt = bs_state;
    fire = 1'b0;
    ev = '0;
    bs_countdown = bs_countdown - 8'd1;
    if (bs_countdown != 8'd0) return;
    bs_countdown = cfg_mirror.scan_period;

    if (pressed != bs_last_pressed) begin
      bs_last_pressed = pressed;
      bs_hold = 8'd0;
      bs_repeat = 8'd0;
      nxt = pressed ? ST_PRESSED : ST_RELEASED;
    end else if (bs_state != ST_RELEASED) begin
      if (bs_hold != HoldMax) bs_hold = bs_hold + 8'd1;
      // Repeat counter runs on the state held before the threshold check
      if (cfg_mirror.repeat_en) begin
        if (bs_repeat != 8'd0) begin
          bs_repeat = bs_repeat - 8'd1;
          if (bs_repeat == 8'd0) rpt = 1'b1;
        end else if (bs_state == ST_LONG) begin
          bs_repeat = cfg_mirror.long_rpt - 8'd1;
        end else if (bs_state == ST_LONGER && cfg_mirror.longer_en) begin
          bs_repeat = cfg_mirror.longer_rpt - 8'd1;
        end
      end
      // Threshold match wins over a repeat in the same scan
      if (bs_hold == cfg_mirror.long_thr) begin
        nxt = ST_LONG;
        rpt = 1'b0;
      end else if (cfg_mirror.longer_en && bs_hold == cfg_mirror.longer_thr) begin
        nxt = ST_LONGER;
        rpt = 1'b0;
      end
    end

    fire = (nxt != bs_state) || rpt;
    bs_state = nxt;
    ev.state = nxt;
    ev.rpt = rpt;
  endfunction

  // Offer one tick word, with random gaps ahead of it
  task automatic send_tick(input logic lvl, input chk_t chk, input btn_state_t st,
                           input logic rpt);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    button_level <= lvl;
    tick_chk <= chk;
    tick_state <= st;
    tick_rpt <= rpt;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every expected word is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (button_events.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SCAN_PERIOD:      cfg_mirror.scan_period = data;
      REG_LONG_THRESHOLD:   cfg_mirror.long_thr = data;
      REG_LONGER_THRESHOLD: cfg_mirror.longer_thr = data;
      REG_LONG_REPEAT:      cfg_mirror.long_rpt = data;
      REG_LONGER_REPEAT:    cfg_mirror.longer_rpt = data;
      REG_REPEAT_ENABLE:    cfg_mirror.repeat_en = data[0];
      REG_LONGER_ENABLE:    cfg_mirror.longer_en = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input setting_t s);
    write_reg(REG_SCAN_PERIOD, s.scan);
    write_reg(REG_LONG_THRESHOLD, s.long_thr);
    write_reg(REG_LONGER_THRESHOLD, s.longer_thr);
    write_reg(REG_LONG_REPEAT, s.long_rpt);
    write_reg(REG_LONGER_REPEAT, s.longer_rpt);
    write_reg(REG_REPEAT_ENABLE, s.repeat_en);
    write_reg(REG_LONGER_ENABLE, s.longer_en);
    cfg_valid <= 1'b0;
    tx_idle = int'(s.tx_idle);
    rx_idle <= int'(s.rx_idle);
  endtask

  // Result side: random stalls, plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin : hold_off
    wait (squeeze_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Predict on every accepted tick, check every accepted result word
  always @(posedge clk) begin : score
    logic       fire;
    press_evt_t ev;
    press_evt_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        ticks_taken++;
        track_button(button_level, fire, ev);
        if (tick_chk == CHK_MODEL && fire) begin
          button_events.push_back(ev);
        end else if (tick_chk == CHK_GIVEN) begin
          want.state = tick_state;
          want.rpt = tick_rpt;
          button_events.push_back(want);
        end
      end
      if (in_valid && !in_ready) stall_cycles++;
      if (out_valid && out_ready) begin
        if (button_events.size() == 0) begin
          $display("%0t: unexpected word: state %0d repeat %0b", $time, button_state,
                   is_repeat);
          errors++;
        end else begin
          want = button_events.pop_front();
          events_seen++;
          if (want.rpt) repeats_seen++;
          if (button_state !== want.state) begin
            $display("%0t: button_state mismatch: expected %0d, actual %0d", $time,
                     want.state, button_state);
            errors++;
          end
          if (is_repeat !== want.rpt) begin
            $display("%0t: is_repeat mismatch: expected %0b, actual %0b", $time,
                     want.rpt, is_repeat);
            errors++;
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("%0t: watchdog expired with %0d words outstanding", $time,
               button_events.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    setting_t  s;
    int        sent;
    int        run;
    logic      first;

    cfg_mirror.scan_period = ScanPeriodRst;
    cfg_mirror.long_thr = LongThrRst;
    cfg_mirror.longer_thr = LongerThrRst;
    cfg_mirror.long_rpt = LongRepeatRst;
    cfg_mirror.longer_rpt = LongerRepeatRst;
    cfg_mirror.repeat_en = RepeatEnRst;
    cfg_mirror.longer_en = LongerEnRst;
    bs_countdown = ScanPeriodRst;
    bs_last_pressed = 1'b0;
    bs_state = ST_RELEASED;
    bs_hold = 8'd0;
    bs_repeat = 8'd0;
    tx_idle = int'(settings[0].tx_idle);
    rx_idle = int'(settings[0].rx_idle);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part; the setup row reprograms mid-countdown
    for (int r = 0; r < NumRows; r++) begin
      row = dir_rows[r];
      if (row.setup) begin
        settle();
        apply_setting(settings[0]);
      end
      for (int k = 0; k < int'(row.reps); k++) begin
        send_tick(row.level, (k == int'(row.reps) - 1) ? row.chk : CHK_NONE, row.state,
                  row.rpt);
      end
    end

    // Random part: press and release runs, some bounce noise
    for (int p = 1; p < NumSettings; p++) begin
      s = settings[p];
      settle();
      apply_setting(s);
      if (s.squeeze) squeeze_req <= 1'b1;
      sent = 0;
      first = 1'b1;
      while (sent < int'(s.items)) begin
        if (!first && $urandom_range(99) < 15) begin
          run = $urandom_range(6, 1);
          repeat (run) begin
            send_tick(1'($urandom_range(1)), CHK_MODEL, ST_RELEASED, 1'b0);
            sent++;
          end
        end else begin
          run = $urandom_range(int'(s.hold_rand), 1);
          repeat (run) begin
            send_tick(1'b1, CHK_MODEL, ST_RELEASED, 1'b0);
            sent++;
          end
          run = first ? int'(s.hold_first) : $urandom_range(int'(s.hold_rand), 1);
          repeat (run) begin
            send_tick(1'b0, CHK_MODEL, ST_RELEASED, 1'b0);
            sent++;
          end
        end
        first = 1'b0;
      end
    end

    settle();
    $display("Ran %0d ticks over %0d register settings; %0d result words checked, %0d repeats.",
             ticks_taken, NumSettings, events_seen, repeats_seen);
    $display("Tick input was stalled for %0d cycles by result back-pressure.", stall_cycles);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== button_long_press_autorepeat.f =====
+incdir+rtl
rtl/blp_pkg.sv
rtl/blp_cfg_regs.sv
rtl/blp_engine.sv
rtl/button_long_press_autorepeat.sv
tb/tb.sv
